FILE: hdl/queue_with_positional_insert_delete_defines.svh
// Assertion macros for the positional-insert queue.
`ifndef QUEUE_WITH_POSITIONAL_INSERT_DELETE_DEFINES_SVH
`define QUEUE_WITH_POSITIONAL_INSERT_DELETE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define QPID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define QPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/qpid_pkg.sv
// Shared types and constants for the positional-insert queue.
package qpid_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int DATA_W        = 32;
  // Wide enough for any position or count up to the largest depth.
  localparam int KW            = 11;
  // Cells per first-level gather group.
  localparam int GRP           = 16;

  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_INS = 2'd2;
  localparam logic [1:0] OP_DEL = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [7:0]               position;
    logic signed [DATA_W-1:0] in_value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]               status;
    logic [7:0]               count;
  } rsp_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [KW-1:0]            pos;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: hdl/qpid_cell.sv
// One queue entry: holds, loads, or shifts from a neighbor per the broadcast op.
module qpid_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  qpid_pkg::cell_ctrl_t              ctrl,
  input  logic signed [qpid_pkg::DATA_W-1:0] left,
  input  logic signed [qpid_pkg::DATA_W-1:0] right,
  output logic signed [qpid_pkg::DATA_W-1:0] data,
  output logic signed [qpid_pkg::DATA_W-1:0] tap
);

  localparam logic [qpid_pkg::KW-1:0] IDX_K = qpid_pkg::KW'(IDX);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (IDX_K == ctrl.pos) begin
        data <= ctrl.value;
      end else if (IDX_K > ctrl.pos) begin
        data <= left;
      end
    end else if (ctrl.del && (IDX_K >= ctrl.pos)) begin
      data <= right;
    end
  end

  // Offer the old value of the deleted entry to the gather tree.
  assign tap = (ctrl.del && (IDX_K == ctrl.pos)) ? data : '0;

endmodule

FILE: hdl/queue_with_positional_insert_delete.sv
// Pipeline: an accepted item passes through the s1 registers (grp_q, s1_status, s1_count),
// then the output registers (rsp, done); no new item is taken while busy. Entries from ctrl.pos
// on shift at once across the cell row; a two-level registered OR tree gathers the removed value.
// busy is high in the cycle after acceptance; the result strobe never waits on the receiver.
// Reset clears the fill count and the pipeline; entry contents stay undefined until written.
module queue_with_positional_insert_delete #(
  parameter int DEPTH = qpid_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  qpid_pkg::cmd_t cmd,
  output logic           done,
  output qpid_pkg::rsp_t rsp
);

  `include "queue_with_positional_insert_delete_defines.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int NGRP  = (DEPTH + qpid_pkg::GRP - 1) / qpid_pkg::GRP;
  localparam logic [qpid_pkg::KW-1:0] DEPTH_K = qpid_pkg::KW'(DEPTH);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  logic                         acc;
  logic [qpid_pkg::KW-1:0]      cnt_k;
  logic [qpid_pkg::KW-1:0]      k;
  logic                         is_ins;
  logic [1:0]                   st;
  qpid_pkg::cell_ctrl_t         ctrl;

  logic signed [qpid_pkg::DATA_W-1:0] data [DEPTH];
  logic signed [qpid_pkg::DATA_W-1:0] tap  [NGRP*qpid_pkg::GRP];
  logic signed [qpid_pkg::DATA_W-1:0] grp_or [NGRP];
  logic signed [qpid_pkg::DATA_W-1:0] grp_q  [NGRP];
  logic signed [qpid_pkg::DATA_W-1:0] gather;

  logic       s1_valid;
  logic [1:0] s1_status;
  logic [7:0] s1_count;

  assign acc   = start && !busy;
  assign busy  = s1_valid;
  assign cnt_k = qpid_pkg::KW'(cnt);

  always_comb begin
    k      = '0;
    is_ins = 1'b0;
    case (cmd.opcode)
      qpid_pkg::OP_ENQ: begin
        k      = cnt_k;
        is_ins = 1'b1;
      end
      qpid_pkg::OP_DEQ: begin
        k      = '0;
        is_ins = 1'b0;
      end
      qpid_pkg::OP_INS: begin
        k      = qpid_pkg::KW'(cmd.position);
        is_ins = 1'b1;
      end
      default: begin
        k      = qpid_pkg::KW'(cmd.position);
        is_ins = 1'b0;
      end
    endcase
  end

  // Position is checked before fullness on insert, emptiness before position on delete.
  always_comb begin
    if (is_ins) begin
      if (k > cnt_k) begin
        st = qpid_pkg::ST_BADPOS;
      end else if (cnt_k >= DEPTH_K) begin
        st = qpid_pkg::ST_FULL;
      end else begin
        st = qpid_pkg::ST_OK;
      end
    end else begin
      if (cnt_k == '0) begin
        st = qpid_pkg::ST_EMPTY;
      end else if (k >= cnt_k) begin
        st = qpid_pkg::ST_BADPOS;
      end else begin
        st = qpid_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    ctrl.ins   = acc && is_ins && (st == qpid_pkg::ST_OK);
    ctrl.del   = acc && !is_ins && (st == qpid_pkg::ST_OK);
    ctrl.pos   = k;
    ctrl.value = cmd.in_value;
  end

  always_comb begin
    cnt_next = cnt;
    if (ctrl.ins) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (ctrl.del) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [qpid_pkg::DATA_W-1:0] left_d;
      logic signed [qpid_pkg::DATA_W-1:0] right_d;
      if (gi == 0) begin : g_head
        assign left_d = cmd.in_value;
      end else begin : g_mid_l
        assign left_d = data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign right_d = data[gi];
      end else begin : g_mid_r
        assign right_d = data[gi+1];
      end
      qpid_cell #(
        .IDX(gi)
      ) u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .left (left_d),
        .right(right_d),
        .data (data[gi]),
        .tap  (tap[gi])
      );
    end
    for (gi = DEPTH; gi < NGRP*qpid_pkg::GRP; gi++) begin : g_pad
      assign tap[gi] = '0;
    end
  endgenerate

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_or[g] = '0;
      for (int j = 0; j < qpid_pkg::GRP; j++) begin
        grp_or[g] = grp_or[g] | tap[g*qpid_pkg::GRP + j];
      end
    end
  end

  always_comb begin
    gather = '0;
    for (int g = 0; g < NGRP; g++) begin
      gather = gather | grp_q[g];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      grp_q     <= grp_or;
      s1_status <= st;
      s1_count  <= 8'(qpid_pkg::KW'(cnt_next));
    end
    rsp.out_value <= gather;
    rsp.status    <= s1_status;
    rsp.count     <= s1_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      cnt      <= cnt_next;
      s1_valid <= acc;
      done     <= s1_valid;
    end
  end

  `QPID_ASSERT_NEXT(a_busy_then_done, busy, done && !busy, "accepted item produced no result")
  `QPID_ASSERT_NOW(a_fail_zero, done && (rsp.status != qpid_pkg::ST_OK), rsp.out_value == '0,
                   "failed operation returned a nonzero value")
  `QPID_ASSERT_NOW(a_cnt_bound, 1'b1, qpid_pkg::KW'(cnt) <= DEPTH_K, "fill count beyond depth")

endmodule
